// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
// Both sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/pepm_pkg.sv -----
`default_nettype none
package pepm_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int WATTS_W  = 24;
    localparam int WH_W     = 32;
    localparam int FRAC_W   = 25;
    localparam int STEP_W   = 7;
    localparam int LIMIT_W  = 23;
    localparam int OUT_TDATA_W = 64;
    localparam int IN_TDATA_W  = 8;

    // Shared divider: dividend is always 25 bits wide
    localparam int DIV_STEPS = FRAC_W;
    localparam int DIV_CNT_W = 5;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POWER_CONSTANT = 3'd0,
        REG_REDUCTION_INTERVAL = 3'd1,
        REG_MAX_REDUCTION_STEPS = 3'd2,
        REG_ENERGY_INCREMENT = 3'd3,
        REG_ENERGY_UNIT = 3'd4,
        REG_IDLE_WARN = 3'd5,
        REG_IDLE_SLEEP = 3'd6
    } cfg_idx_t;

    // Register reset values
    localparam logic [23:0] RST_POWER_CONSTANT = 24'd79646;
    localparam logic [15:0] RST_REDUCTION_INTERVAL = 16'd1000;
    localparam logic [6:0]  RST_MAX_REDUCTION_STEPS = 7'd90;
    localparam logic [23:0] RST_ENERGY_INCREMENT = 24'd353984;
    localparam logic [23:0] RST_ENERGY_UNIT = 24'd1000000;
    localparam logic [31:0] RST_IDLE_WARN = 32'd50000;
    localparam logic [31:0] RST_IDLE_SLEEP = 32'd200000;

    typedef struct packed {
        logic [23:0] power_constant;
        logic [15:0] reduction_interval_ms;
        logic [6:0]  max_reduction_steps;
        logic [23:0] energy_increment;
        logic [23:0] energy_unit;
        logic [31:0] idle_warn_ms;
        logic [31:0] idle_sleep_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PDIV,
        ST_EDIV,
        ST_FINISH
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic sample;
        logic step;
        logic power_done;
        logic energy_done;
        logic load_energy;
        logic emit;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic power_req;
        logic energy_req;
        logic energy_pend;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- design/pulse_energy_power_meter.sv -----
`default_nettype none
// Channel     Dir  Handshake                    Word
// s_axis      in   s_axis_tvalid/s_axis_tready  one sample: ms_tick, hf_level, lf_level
// m_axis      out  m_axis_tvalid/m_axis_tready  one result: watts, energy_wh, flags
// cfg         in   cfg_we (no wait)             register index + write data
//
// Sequence: a sample that needs no division is accepted, then its result is
// registered. A high-frequency edge or a decay step adds a power division and a
// watt-hour carry an energy division, run in turn on the single shared restoring
// divider, 25 quotient bits at one bit per cycle.
// Reset: asynchronous, active low; counters, flags and config registers take their
// documented values at once, no clearing pass; divider/result data are not reset.
// Stalls: a new sample is taken only when the previous one has finished; the
// result sits in an output register, so the next sample is taken while it waits.
module pulse_energy_power_meter #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] ms_tick, [1] hf_level, [2] lf_level
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [23:0] watts, [55:24] energy_wh,
                                             // [56] idle_warn, [57] idle_sleep
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    pepm_pkg::cfg_t cfg;
    pepm_pkg::cmd_t cmd;
    pepm_pkg::sts_t sts;

    pepm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencer: idle -> power divide (if needed) -> energy divide (if needed) -> result
    pepm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Counters, edge detect, decay, energy fraction, divider, output register
    pepm_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ms_tick   (s_axis_tdata[0]),
        .hf_level  (s_axis_tdata[1]),
        .lf_level  (s_axis_tdata[2]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- design/pepm_cfg_regs.sv -----
`default_nettype none
module pepm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pepm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pepm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pepm_pkg::cfg_t                        cfg
);

    pepm_pkg::cfg_t cfg_reg;
    pepm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (pepm_pkg::cfg_idx_t'(cfg_addr))
                pepm_pkg::REG_POWER_CONSTANT:
                    cfg_next.power_constant = cfg_wdata[23:0];
                pepm_pkg::REG_REDUCTION_INTERVAL:
                    cfg_next.reduction_interval_ms = cfg_wdata[15:0];
                pepm_pkg::REG_MAX_REDUCTION_STEPS:
                    cfg_next.max_reduction_steps = cfg_wdata[6:0];
                pepm_pkg::REG_ENERGY_INCREMENT:
                    cfg_next.energy_increment = cfg_wdata[23:0];
                pepm_pkg::REG_ENERGY_UNIT:
                    cfg_next.energy_unit = cfg_wdata[23:0];
                pepm_pkg::REG_IDLE_WARN:
                    cfg_next.idle_warn_ms = cfg_wdata;
                pepm_pkg::REG_IDLE_SLEEP:
                    cfg_next.idle_sleep_ms = cfg_wdata;
                default:
                    cfg_next = cfg_reg;  // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_constant <= pepm_pkg::RST_POWER_CONSTANT;
            cfg_reg.reduction_interval_ms <= pepm_pkg::RST_REDUCTION_INTERVAL;
            cfg_reg.max_reduction_steps <= pepm_pkg::RST_MAX_REDUCTION_STEPS;
            cfg_reg.energy_increment <= pepm_pkg::RST_ENERGY_INCREMENT;
            cfg_reg.energy_unit <= pepm_pkg::RST_ENERGY_UNIT;
            cfg_reg.idle_warn_ms <= pepm_pkg::RST_IDLE_WARN;
            cfg_reg.idle_sleep_ms <= pepm_pkg::RST_IDLE_SLEEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- design/pepm_ctrl.sv -----
`default_nettype none
module pepm_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire pepm_pkg::sts_t sts,
    output pepm_pkg::cmd_t cmd
);

    pepm_pkg::state_t state_reg;
    pepm_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pepm_pkg::ST_IDLE:
                if (in_valid)
                begin
                    if (sts.power_req)
                        state_next = pepm_pkg::ST_PDIV;
                    else if (sts.energy_req)
                        state_next = pepm_pkg::ST_EDIV;
                    else
                        state_next = pepm_pkg::ST_FINISH;
                end
            pepm_pkg::ST_PDIV:
                if (sts.div_last)
                    state_next = sts.energy_pend ? pepm_pkg::ST_EDIV : pepm_pkg::ST_FINISH;
            pepm_pkg::ST_EDIV:
                if (sts.div_last)
                    state_next = pepm_pkg::ST_FINISH;
            pepm_pkg::ST_FINISH:
                if (sts.out_free)
                    state_next = pepm_pkg::ST_IDLE;
            default:
                state_next = pepm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            pepm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.sample = in_valid;
            end
            pepm_pkg::ST_PDIV:
            begin
                cmd.step = 1'b1;
                cmd.power_done = sts.div_last;
                cmd.load_energy = sts.div_last & sts.energy_pend;
            end
            pepm_pkg::ST_EDIV:
            begin
                cmd.step = 1'b1;
                cmd.energy_done = sts.div_last;
            end
            pepm_pkg::ST_FINISH:
                cmd.emit = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pepm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ----- design/pepm_datapath.sv -----
`default_nettype none
module pepm_datapath #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pepm_pkg::cfg_t                    cfg,
    input  wire logic                              ms_tick,
    input  wire logic                              hf_level,
    input  wire logic                              lf_level,
    input  wire pepm_pkg::cmd_t                    cmd,
    output pepm_pkg::sts_t                         sts,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [pepm_pkg::OUT_TDATA_W-1:0]       out_data
);

    localparam int DIV_W = (COUNTER_BITS > 24) ? COUNTER_BITS : 24;
    localparam int CMP_W = (COUNTER_BITS > pepm_pkg::LIMIT_W) ? COUNTER_BITS
                                                                : pepm_pkg::LIMIT_W;
    localparam int FW = pepm_pkg::FRAC_W;

    // Architectural state
    logic [COUNTER_BITS-1:0]       hf_el_reg, lf_el_reg, last_period_reg;
    logic [pepm_pkg::STEP_W-1:0]   decay_step_reg;
    logic                          awaiting_reg, hf_seen_reg, lf_seen_reg;
    logic [FW-1:0]                 frac_reg;
    logic [pepm_pkg::WH_W-1:0]     wh_reg;
    logic [pepm_pkg::WATTS_W-1:0]  power_reg;
    logic                          e_pend_reg;
    logic                          out_valid_reg;

    // Payload
    logic [FW-1:0]                 e_dividend_reg;
    logic [23:0]                   e_divisor_reg;
    logic [DIV_W-1:0]              div_rem_reg, div_dsr_reg;
    logic [FW-1:0]                 div_quo_reg;
    logic [pepm_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [pepm_pkg::OUT_TDATA_W-1:0] out_data_reg;

    // Per-sample logic
    logic [COUNTER_BITS-1:0]       hf_t, lf_t, period;
    logic                          hf_edge, lf_edge;
    logic [pepm_pkg::LIMIT_W-1:0]  limit;
    logic                          decay_due, decay_go;
    logic [23:0]                   unit_eff;
    logic [FW-1:0]                 e_sum;
    logic                          power_req, energy_req;
    logic                          warn, sleep;

    // Divider step
    logic [DIV_W:0]                rem_sh;
    logic [DIV_W-1:0]              rem_next;
    logic [FW-1:0]                 quo_next;

    always_comb
    begin
        hf_t = (ms_tick && hf_el_reg != '1) ? hf_el_reg + 1'b1 : hf_el_reg;
        lf_t = (ms_tick && lf_el_reg != '1) ? lf_el_reg + 1'b1 : lf_el_reg;
        period = (hf_t == '0) ? COUNTER_BITS'(1) : hf_t;
        hf_edge = !hf_level && !hf_seen_reg;
        lf_edge = !lf_level && !lf_seen_reg;

        limit = pepm_pkg::LIMIT_W'(cfg.reduction_interval_ms)
              * pepm_pkg::LIMIT_W'(decay_step_reg);
        decay_due = !awaiting_reg && !hf_edge
                  && (CMP_W'(hf_t) > CMP_W'(last_period_reg))
                  && (CMP_W'(hf_t) > CMP_W'(limit));
        decay_go = decay_due && (decay_step_reg < cfg.max_reduction_steps);
        power_req = hf_edge || decay_go;

        unit_eff = (cfg.energy_unit == '0) ? 24'd1 : cfg.energy_unit;
        e_sum = frac_reg + FW'(cfg.energy_increment);
        energy_req = lf_edge && (e_sum > FW'(unit_eff));

        warn = pepm_pkg::WH_W'(lf_el_reg) >= cfg.idle_warn_ms;
        sleep = pepm_pkg::WH_W'(lf_el_reg) >= cfg.idle_sleep_ms;
    end

    // Restoring divider, one quotient bit per cycle
    always_comb
    begin
        rem_sh = {div_rem_reg, div_quo_reg[FW-1]};
        if (rem_sh >= {1'b0, div_dsr_reg})
        begin
            rem_next = DIV_W'(rem_sh - {1'b0, div_dsr_reg});
            quo_next = {div_quo_reg[FW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[DIV_W-1:0];
            quo_next = {div_quo_reg[FW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_el_reg <= '0;
            lf_el_reg <= '0;
            last_period_reg <= '1;
            decay_step_reg <= pepm_pkg::STEP_W'(1);
            awaiting_reg <= 1'b1;
            hf_seen_reg <= 1'b0;
            lf_seen_reg <= 1'b0;
            frac_reg <= '0;
            wh_reg <= '0;
            power_reg <= '0;
            e_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sample)
            begin
                hf_el_reg <= hf_edge ? '0 : hf_t;
                lf_el_reg <= lf_edge ? '0 : lf_t;
                hf_seen_reg <= !hf_level;
                lf_seen_reg <= !lf_level;
                e_pend_reg <= energy_req;
                if (hf_edge)
                begin
                    last_period_reg <= hf_t;
                    decay_step_reg <= pepm_pkg::STEP_W'(1);
                    awaiting_reg <= 1'b0;
                end
                else if (decay_go)
                    decay_step_reg <= decay_step_reg + 1'b1;
                if (decay_due && !decay_go)
                    power_reg <= '0;
                if (lf_edge && !energy_req)
                    frac_reg <= e_sum;
            end
            if (cmd.power_done)
                power_reg <= quo_next[pepm_pkg::WATTS_W-1:0];
            if (cmd.energy_done)
            begin
                wh_reg <= wh_reg + pepm_pkg::WH_W'(quo_next);
                // remainder is below the unit, so it fits 24 bits
                frac_reg <= {1'b0, rem_next[23:0]} + FW'(1);
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample)
        begin
            e_dividend_reg <= e_sum - FW'(1);
            e_divisor_reg <= unit_eff;
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
            if (power_req)
            begin
                div_quo_reg <= FW'(cfg.power_constant);
                div_dsr_reg <= DIV_W'(period);
            end
            else
            begin
                div_quo_reg <= e_sum - FW'(1);
                div_dsr_reg <= DIV_W'(unit_eff);
            end
        end
        else if (cmd.load_energy)
        begin
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
            div_quo_reg <= e_dividend_reg;
            div_dsr_reg <= DIV_W'(e_divisor_reg);
        end
        else if (cmd.step)
        begin
            div_rem_reg <= rem_next;
            div_quo_reg <= quo_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.emit)
            out_data_reg <= {6'b0, sleep, warn, wh_reg, power_reg};
    end

    always_comb
    begin
        sts.power_req = power_req;
        sts.energy_req = energy_req;
        sts.energy_pend = e_pend_reg;
        sts.div_last = div_cnt_reg == pepm_pkg::DIV_CNT_W'(pepm_pkg::DIV_STEPS - 1);
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule
`default_nettype wire

// ----- design/pepm_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module pepm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // stalled result word holds
    `CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one sample in flight: ready drops right after a word is taken
    `CHK_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // ready returns only together with a fresh result
    `CHK_SAME(a_ready_with_result, $rose(s_axis_tready), m_axis_tvalid)

    // reserved bits of the result word stay zero
    `CHK_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[63:58] == 6'b0)

endmodule

bind pulse_energy_power_meter pepm_checker u_pepm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
